@@ src/gsm_pkg.sv @@
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared types and codes for the generational slot map.
// ----------------------------------------------------------------------------
package gsm_pkg;

  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int KEY_GEN_W = 32;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOOK = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_CHK2 = 7'b0001000,
    S_MOVE = 7'b0010000,
    S_FREE = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic check2;
    logic move;
    logic free_upd;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_getrem;
    logic is_remove;
    logic key_ok;
    logic live;
    logic need_move;
  } sts_t;

endpackage

@@ src/gsm_ram.sv @@
// ----------------------------------------------------------------------------
// gsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/gsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// gsm_ctrl
// Sequencer for insert, get and remove beats.
// ----------------------------------------------------------------------------
module gsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_stall,
  input  gsm_pkg::sts_t sts,
  output gsm_pkg::cmd_t cmd,
  output logic          in_stall,
  output logic          out_valid
);
  import gsm_pkg::*;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.is_getrem && sts.key_ok) state_nxt = S_CHK2;
        else state_nxt = S_DONE;
      end
      S_CHK2: begin
        if (sts.is_remove && sts.live) state_nxt = sts.need_move ? S_MOVE : S_FREE;
        else state_nxt = S_DONE;
      end
      S_MOVE: state_nxt = S_FREE;
      S_FREE: state_nxt = S_DONE;
      S_DONE: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Drive commands
  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.check    = (state_r == S_CHK);
  assign cmd.check2   = (state_r == S_CHK2);
  assign cmd.move     = (state_r == S_MOVE);
  assign cmd.free_upd = (state_r == S_FREE);
  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_DONE);

endmodule

@@ src/gsm_dp.sv @@
// ----------------------------------------------------------------------------
// gsm_dp
// Datapath: slot and value memories, counters, free list and result beat.
// ----------------------------------------------------------------------------
module gsm_dp #(
  parameter int SLOTS      = 256,
  parameter int VALUE_BITS = 32,
  parameter int GEN_BITS   = 32,
  parameter int IDX_W      = $clog2(SLOTS),
  parameter int CNT_W      = $clog2(SLOTS + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gsm_pkg::cmd_t                      cmd,
  output gsm_pkg::sts_t                      sts,
  input  logic [gsm_pkg::ACTION_W-1:0]       in_action,
  input  logic [IDX_W-1:0]                   in_key_index,
  input  logic [gsm_pkg::KEY_GEN_W-1:0]      in_key_generation,
  input  logic [VALUE_BITS-1:0]              in_value_in,
  output logic [gsm_pkg::STATUS_W-1:0]       out_status,
  output logic [IDX_W-1:0]                   out_key_index_out,
  output logic [gsm_pkg::KEY_GEN_W-1:0]      out_key_generation_out,
  output logic [VALUE_BITS-1:0]              out_value_out
);
  import gsm_pkg::*;

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  // Captured beat
  logic [ACTION_W-1:0]  act_r;
  logic [IDX_W-1:0]     idx_r;
  logic [KEY_GEN_W-1:0] kgen_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IDX_W-1:0]     pos_r;
  logic [GEN_BITS-1:0]  gen_r;

  // Map state
  logic [CNT_W-1:0] slot_cnt_r, val_cnt_r;
  logic [IDX_W-1:0] free_head_r, free_tail_r;
  logic             free_empty_r;

  // Result beat
  logic [STATUS_W-1:0]   res_status_r;
  logic [IDX_W-1:0]      res_kidx_r;
  logic [KEY_GEN_W-1:0]  res_kgen_r;
  logic [VALUE_BITS-1:0] res_val_r;

  // Memory ports
  logic                  link_we, gen_we, own_we, sto_we;
  logic [IDX_W-1:0]      link_wa, gen_wa, own_wa, sto_wa;
  logic [IDX_W-1:0]      link_wd, own_wd;
  logic [GEN_BITS-1:0]   gen_wd;
  logic [VALUE_BITS-1:0] sto_wd;
  logic [IDX_W-1:0]      slot_ra, val_ra;
  logic [IDX_W-1:0]      link_q, own_q;
  logic [GEN_BITS-1:0]   gen_q;
  logic [VALUE_BITS-1:0] sto_q;

  // Insert slot choice
  logic             ins_ok, ins_new, ins_fit;
  logic [IDX_W-1:0] ins_slot;
  logic [CNT_W-1:0] last_cnt;

  gsm_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(slot_ra), .rdata(link_q));
  gsm_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen (
    .clk(clk), .we(gen_we), .waddr(gen_wa), .wdata(gen_wd),
    .raddr(slot_ra), .rdata(gen_q));
  gsm_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
    .raddr(val_ra), .rdata(own_q));
  gsm_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_store (
    .clk(clk), .we(sto_we), .waddr(sto_wa), .wdata(sto_wd),
    .raddr(val_ra), .rdata(sto_q));

  // Decode status
  assign last_cnt      = val_cnt_r - CNT_W'(1);
  assign sts.is_insert = (act_r == ACT_INSERT);
  assign sts.is_getrem = (act_r == ACT_GET) || (act_r == ACT_REMOVE);
  assign sts.is_remove = (act_r == ACT_REMOVE);
  assign sts.key_ok    = (CNT_W'(idx_r) < slot_cnt_r)
                      && (KEY_GEN_W'(gen_q) == kgen_r)
                      && (CNT_W'(link_q) < val_cnt_r);
  assign sts.live      = (own_q == idx_r);
  assign sts.need_move = (CNT_W'(pos_r) < last_cnt);

  // Pick the insert slot
  assign ins_new  = free_empty_r && (slot_cnt_r < SLOTS_C);
  assign ins_ok   = !free_empty_r || ins_new;
  assign ins_slot = free_empty_r ? slot_cnt_r[IDX_W-1:0] : free_head_r;
  assign ins_fit  = ins_ok && (val_cnt_r < SLOTS_C);

  // Read addresses
  assign slot_ra = sts.is_insert ? free_head_r : idx_r;
  assign val_ra  = cmd.check2 ? last_cnt[IDX_W-1:0] : link_q;

  // Write ports
  always_comb begin
    link_we = 1'b0; link_wa = ins_slot; link_wd = val_cnt_r[IDX_W-1:0];
    gen_we  = 1'b0; gen_wa  = ins_slot; gen_wd  = GEN_BITS'(1);
    own_we  = 1'b0; own_wa  = val_cnt_r[IDX_W-1:0]; own_wd = ins_slot;
    sto_we  = 1'b0; sto_wa  = val_cnt_r[IDX_W-1:0]; sto_wd = val_r;
    if (cmd.check && sts.is_insert) begin
      gen_we  = ins_new;
      link_we = ins_fit;
      own_we  = ins_fit;
      sto_we  = ins_fit;
    end
    if (cmd.check2 && sts.is_remove && sts.live) begin
      gen_we = 1'b1;
      gen_wa = idx_r;
      gen_wd = gen_r + GEN_BITS'(1);
    end
    if (cmd.move) begin
      sto_we  = 1'b1; sto_wa = pos_r; sto_wd = sto_q;
      own_we  = 1'b1; own_wa = pos_r; own_wd = own_q;
      link_we = 1'b1; link_wa = own_q; link_wd = pos_r;
    end
    if (cmd.free_upd) begin
      link_we = !free_empty_r;
      link_wa = idx_r;
      link_wd = free_head_r;
    end
  end

  // Capture beat and hold key data
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      idx_r  <= in_key_index;
      kgen_r <= in_key_generation;
      val_r  <= in_value_in;
    end
    if (cmd.check) begin
      pos_r <= link_q;
      gen_r <= gen_q;
    end
  end

  // Update counters and free list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r   <= '0;
      val_cnt_r    <= '0;
      free_head_r  <= '0;
      free_tail_r  <= '0;
      free_empty_r <= 1'b1;
    end else begin
      if (cmd.check && sts.is_insert) begin
        if (!free_empty_r) begin
          if (free_tail_r != free_head_r) free_head_r <= link_q;
          else free_empty_r <= 1'b1;
        end else if (ins_new) begin
          slot_cnt_r <= slot_cnt_r + CNT_W'(1);
        end
        if (ins_fit) val_cnt_r <= val_cnt_r + CNT_W'(1);
      end
      if (cmd.check2 && sts.is_remove && sts.live) begin
        val_cnt_r <= last_cnt;
      end
      if (cmd.free_upd) begin
        if (free_empty_r) free_tail_r <= idx_r;
        free_head_r  <= idx_r;
        free_empty_r <= 1'b0;
      end
    end
  end

  // Build result beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= ST_STALE;
      res_kidx_r   <= '0;
      res_kgen_r   <= '0;
      res_val_r    <= '0;
    end
    if (cmd.check && sts.is_insert) begin
      if (ins_fit) begin
        res_status_r <= ST_OK;
        res_kidx_r   <= ins_slot;
        res_kgen_r   <= ins_new ? KEY_GEN_W'(1) : KEY_GEN_W'(gen_q);
      end else begin
        res_status_r <= ST_FULL;
      end
    end
    if (cmd.check2 && sts.live) begin
      res_status_r <= ST_OK;
      res_val_r    <= sto_q;
    end
  end

  assign out_status             = res_status_r;
  assign out_key_index_out      = res_kidx_r;
  assign out_key_generation_out = res_kgen_r;
  assign out_value_out          = res_val_r;

`ifndef SYNTH
  a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    val_cnt_r <= slot_cnt_r) else $error("value count above slot count");
  a_sc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= SLOTS_C) else $error("slot count above capacity");
  a_rm_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check2 && sts.is_remove && sts.live) |=> (val_cnt_r == $past(last_cnt)))
    else $error("remove did not shrink value store");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check && sts.is_insert && !ins_ok) |=> (res_status_r == ST_FULL))
    else $error("full insert not reported");
`endif

endmodule

@@ src/generational_slot_map.sv @@
// ----------------------------------------------------------------------------
// generational_slot_map
// Fixed-capacity slot map with generational keys and a dense value store.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_stall    | action, key_index, key_generation, value_in
// out_    | output    | out_valid / out_stall  | status, key_index_out, key_generation_out,
//         |           |                        | value_out
// Insert, unknown actions and keys failing the range, generation or link check
// pass the look and check states before the result is offered; get and keys
// naming a free slot add a second check state; remove adds the free-list link
// write, preceded by the hole fill when the last value moves into the hole (two
// dependent reads first). The map goes back to idle after the result beat is
// taken. One beat is in flight at a time; in_stall is high until the result leaves.
// Reset is synchronous; memories need no clearing pass.
// A stalled result holds in its register until out_stall drops.
// ----------------------------------------------------------------------------
module generational_slot_map #(
  parameter int SLOTS      = 256,
  parameter int VALUE_BITS = 32,
  parameter int GEN_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gsm_pkg::ACTION_W-1:0]       in_action,
  input  logic [$clog2(SLOTS)-1:0]           in_key_index,
  input  logic [gsm_pkg::KEY_GEN_W-1:0]      in_key_generation,
  input  logic [VALUE_BITS-1:0]              in_value_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gsm_pkg::STATUS_W-1:0]       out_status,
  output logic [$clog2(SLOTS)-1:0]           out_key_index_out,
  output logic [gsm_pkg::KEY_GEN_W-1:0]      out_key_generation_out,
  output logic [VALUE_BITS-1:0]              out_value_out
);
  import gsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the beat
  gsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid));

  // Hold map state and results
  gsm_dp #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS), .GEN_BITS(GEN_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_key_index(in_key_index),
    .in_key_generation(in_key_generation), .in_value_in(in_value_in),
    .out_status(out_status), .out_key_index_out(out_key_index_out),
    .out_key_generation_out(out_key_generation_out),
    .out_value_out(out_value_out));

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational slot map. A directed table walks
// the corner cases (empty map, extreme values, stale and free-slot keys, hole
// fill, free-list reuse, unknown action). Random phases then fill the map to
// full, drain it and mix traffic, mostly with live keys taken from the
// bench's own slot map copy. Both channels idle and stall at random; every
// result beat is checked field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsm_pkg::*;

  localparam int NSLOT = 256;
  localparam int N_RANDOM = 1720;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [7:0]          key_index;
    logic [31:0]         key_gen;
    logic [31:0]         value;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          key_index;
    logic [31:0]         key_gen;
    logic [31:0]         value;
  } res_t;

  typedef struct packed {
    op_t  op;
    logic typed;
    res_t res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [ACTION_W-1:0] in_action;
  logic [7:0] in_key_index, out_key_index_out;
  logic [31:0] in_key_generation, in_value_in, out_key_generation_out, out_value_out;
  logic [STATUS_W-1:0] out_status;

  generational_slot_map DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_key_index(in_key_index),
    .in_key_generation(in_key_generation), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_key_index_out(out_key_index_out),
    .out_key_generation_out(out_key_generation_out), .out_value_out(out_value_out)
  );

  // Bench copy of the map state
  logic [7:0]  link_q [NSLOT];
  logic [31:0] gen_q [NSLOT];
  logic [7:0]  owner_q [NSLOT];
  logic [31:0] store_q [NSLOT];
  int slots_used, values_used;
  logic [7:0] fl_head, fl_tail;
  logic fl_empty;

  res_t pending_res[$];
  row_t table_q[$];
  int table_pos;
  bit in_table;
  int errors, mismatches, idle_count;
  int n_ins, n_get, n_rem, n_full, n_stale;
  bit quiet, hold_req, hold_done;

  function automatic bit key_live(logic [7:0] idx, logic [31:0] gen);
    if (idx >= slots_used) return 0;
    if (gen_q[idx] != gen) return 0;
    if (link_q[idx] >= values_used) return 0;
    return owner_q[link_q[idx]] == idx;
  endfunction

  // Apply one operation to the map copy and return its result
  function automatic res_t map_apply(op_t op);
    res_t r;
    logic [7:0] s, pos, last, mover;
    bit got;
    r = '0;
    r.status = ST_STALE;
    got = 1;
    case (op.action)
      ACT_INSERT: begin
        if (!fl_empty) begin
          s = fl_head;
          if (fl_tail != fl_head) fl_head = link_q[s];
          else fl_empty = 1;
        end else if (slots_used < NSLOT) begin
          s = slots_used[7:0];
          slots_used++;
          gen_q[s] = 32'd1;
        end else begin
          got = 0;
        end
        if (got && values_used < NSLOT) begin
          link_q[s] = values_used[7:0];
          store_q[values_used] = op.value;
          owner_q[values_used] = s;
          values_used++;
          r.status = ST_OK;
          r.key_index = s;
          r.key_gen = gen_q[s];
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_GET: begin
        if (key_live(op.key_index, op.key_gen)) begin
          r.status = ST_OK;
          r.value = store_q[link_q[op.key_index]];
        end
      end
      ACT_REMOVE: begin
        if (key_live(op.key_index, op.key_gen)) begin
          pos = link_q[op.key_index];
          r.status = ST_OK;
          r.value = store_q[pos];
          gen_q[op.key_index] = gen_q[op.key_index] + 32'd1;
          values_used--;
          last = values_used[7:0];
          if (pos < last) begin
            mover = owner_q[last];
            store_q[pos] = store_q[last];
            owner_q[pos] = mover;
            link_q[mover] = pos;
          end
          if (!fl_empty) link_q[op.key_index] = fl_head;
          else fl_tail = op.key_index;
          fl_head = op.key_index;
          fl_empty = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random operation, biased by phase: 0 fill, 1 drain, 2 mixed
  function automatic op_t make_op(int phase);
    op_t op;
    int pct, ins_pct, p, slot;
    op.value = $urandom;
    op.key_gen = $urandom;
    op.key_index = 8'($urandom);
    ins_pct = (phase == 0) ? 75 : (phase == 1) ? 15 : 40;
    pct = $urandom_range(99);
    if (pct < ins_pct) begin
      op.action = ACT_INSERT;
      return op;
    end
    op.action = ($urandom_range(1) != 0) ? ACT_GET : ACT_REMOVE;
    pct = $urandom_range(99);
    if (pct < 80 && values_used > 0) begin
      // live key
      p = $urandom_range(values_used - 1);
      slot = int'(owner_q[p]);
      op.key_index = 8'(slot);
      op.key_gen = gen_q[slot];
    end else if (pct < 90 && slots_used > 0) begin
      // known slot, stale or off-by-one generation
      slot = $urandom_range(slots_used - 1);
      op.key_index = 8'(slot);
      op.key_gen = gen_q[slot] + (($urandom_range(1) != 0) ? 32'd1 : -32'd1);
    end else if (pct < 95) begin
      op.action = ACT_UNUSED;
    end
    return op;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Predict on input beats, check on output beats
  always @(posedge clk) begin
    res_t r, want;
    op_t op;
    row_t row;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        op = '{in_action, in_key_index, in_key_generation, in_value_in};
        r = map_apply(op);
        if (in_table) begin
          row = table_q[table_pos];
          if (row.typed) r = row.res;
        end
        pending_res.push_back(r);
        case (op.action)
          ACT_INSERT: n_ins++;
          ACT_GET:    n_get++;
          ACT_REMOVE: n_rem++;
          default:    ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_res.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("%0t: result beat with nothing pending", $realtime);
        end else begin
          want = pending_res.pop_front();
          if (out_status == ST_FULL) n_full++;
          if (out_status == ST_STALE) n_stale++;
          if (out_status !== want.status || out_key_index_out !== want.key_index ||
              out_key_generation_out !== want.key_gen || out_value_out !== want.value) begin
            errors++;
            if (mismatches++ < 10)
              $display("%0t: mismatch exp st=%0d idx=%0d gen=%h val=%h got st=%0d idx=%0d gen=%h val=%h",
                       $realtime, want.status, want.key_index, want.key_gen, want.value,
                       out_status, out_key_index_out, out_key_generation_out, out_value_out);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > STALL_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off
  initial begin
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end
      out_stall <= !quiet && ($urandom_range(99) < 22);
    end
  end

  task automatic send(op_t op);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_action <= op.action;
    in_key_index <= op.key_index;
    in_key_generation <= op.key_gen;
    in_value_in <= op.value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic row_t row(logic [ACTION_W-1:0] a, logic [7:0] i, logic [31:0] g,
                               logic [31:0] v, logic t, logic [STATUS_W-1:0] s,
                               logic [7:0] ki, logic [31:0] kg, logic [31:0] vo);
    return '{'{a, i, g, v}, t, '{s, ki, kg, vo}};
  endfunction

  // Stimulus
  initial begin
    int phase;
    errors = 0; mismatches = 0; idle_count = 0;
    n_ins = 0; n_get = 0; n_rem = 0; n_full = 0; n_stale = 0;
    slots_used = 0; values_used = 0; fl_head = 0; fl_tail = 0; fl_empty = 1;
    quiet = 0; hold_req = 0; hold_done = 0; in_table = 0; table_pos = 0;
    rst_n = 0; in_valid = 0;
    in_action = ACT_INSERT; in_key_index = 0; in_key_generation = 0; in_value_in = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed corner cases; typed rows carry their own expected result
    table_q = '{
      row(ACT_GET,    8'd0,   32'd1, 32'h0, 1, ST_STALE, 8'd0, 32'd0, 32'h0),        // empty map
      row(ACT_INSERT, 8'd0,   32'd0, 32'h0, 1, ST_OK, 8'd0, 32'd1, 32'h0),
      row(ACT_INSERT, 8'hFF,  32'hFFFFFFFF, 32'hFFFFFFFF, 1, ST_OK, 8'd1, 32'd1, 32'h0),
      row(ACT_GET,    8'd0,   32'd1, 32'h0, 1, ST_OK, 8'd0, 32'd0, 32'h0),
      row(ACT_GET,    8'd1,   32'd1, 32'h0, 1, ST_OK, 8'd0, 32'd0, 32'hFFFFFFFF),
      row(ACT_GET,    8'd1,   32'hFFFFFFFF, 32'h0, 1, ST_STALE, 8'd0, 32'd0, 32'h0),
      row(ACT_GET,    8'hFF,  32'd1, 32'h0, 1, ST_STALE, 8'd0, 32'd0, 32'h0),       // out of range
      row(ACT_UNUSED, 8'd0,   32'd1, 32'hFFFFFFFF, 1, ST_STALE, 8'd0, 32'd0, 32'h0),
      row(ACT_REMOVE, 8'd0,   32'd1, 32'h0, 1, ST_OK, 8'd0, 32'd0, 32'h0),          // hole fill
      row(ACT_GET,    8'd0,   32'd1, 32'h0, 1, ST_STALE, 8'd0, 32'd0, 32'h0),
      row(ACT_GET,    8'd0,   32'd2, 32'h0, 1, ST_STALE, 8'd0, 32'd0, 32'h0),       // free slot
      row(ACT_GET,    8'd1,   32'd1, 32'h0, 1, ST_OK, 8'd0, 32'd0, 32'hFFFFFFFF),
      row(ACT_INSERT, 8'd0,   32'd0, 32'h12345678, 1, ST_OK, 8'd0, 32'd2, 32'h0),   // reuse
      row(ACT_REMOVE, 8'd1,   32'd1, 32'h0, 1, ST_OK, 8'd0, 32'd0, 32'hFFFFFFFF),
      row(ACT_REMOVE, 8'd1,   32'd1, 32'h0, 1, ST_STALE, 8'd0, 32'd0, 32'h0),
      row(ACT_INSERT, 8'd0,   32'd0, 32'hA5A5A5A5, 1, ST_OK, 8'd1, 32'd2, 32'h0),
      row(ACT_REMOVE, 8'd0,   32'd2, 32'h0, 0, ST_OK, 8'd0, 32'd0, 32'h0),
      row(ACT_REMOVE, 8'd1,   32'd2, 32'h0, 0, ST_OK, 8'd0, 32'd0, 32'h0),
      row(ACT_INSERT, 8'd0,   32'd0, 32'h5A5A5A5A, 1, ST_OK, 8'd1, 32'd3, 32'h0),   // LIFO
      row(ACT_INSERT, 8'd0,   32'd0, 32'h0F0F0F0F, 1, ST_OK, 8'd0, 32'd3, 32'h0),
      row(ACT_INSERT, 8'd0,   32'd0, 32'h00000001, 0, ST_OK, 8'd0, 32'd0, 32'h0),
      row(ACT_GET,    8'd2,   32'd1, 32'h0, 0, ST_OK, 8'd0, 32'd0, 32'h0)
    };
    in_table = 1;
    for (table_pos = 0; table_pos < table_q.size(); table_pos++) send(table_q[table_pos].op);
    in_table = 0;

    // Random phases: fill to full, drain, fill again, then mixed
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n < 500) ? 0 : (n < 900) ? 1 : (n < 1200) ? 0 : 2;
      quiet = (n >= 1300 && n < 1450);
      if (n == 200) hold_req = 1;
      if (n == 1000) begin
        in_valid <= 0;
        wait (pending_res.size() == 0);
        @(negedge clk);
      end
      send(make_op(phase));
    end
    in_valid <= 0;
    quiet = 1;

    wait (pending_res.size() == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d inserts, %0d gets, %0d removes plus directed corners;",
             n_ins, n_get, n_rem);
    $display("%0d full and %0d stale-key results seen.", n_full, n_stale);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/gsm_pkg.sv
src/gsm_ram.sv
src/gsm_ctrl.sv
src/gsm_dp.sv
src/generational_slot_map.sv
sim/tb_top.sv
